>>> src/msss_pkg.sv
// ----------------------------------------------------------------------------
// msss_pkg: shared types, codes and helpers of the servo slew sequencer
// Holds the field widths, register reset values, action and motion codes
// and the small helpers of the core; the checker shares its codes and widths.
// ----------------------------------------------------------------------------
package msss_pkg;

   localparam int unsigned NUM_SERVOS_DEFAULT = 5;

   localparam int unsigned ANGLE_W    = 8;
   localparam int unsigned INTERVAL_W = 10;
   localparam int unsigned ACTION_W   = 3;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned CHAN_W     = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 16;

   typedef logic [ANGLE_W-1:0]    angle_type;
   typedef logic [INTERVAL_W-1:0] interval_type;
   typedef logic [MODE_W-1:0]     mode_type;

   // Register reset values
   localparam angle_type    STEP_RESET     = 8'd5;
   localparam interval_type INTERVAL_RESET = 10'd20;
   localparam angle_type    MIN_RESET      = 8'd20;
   localparam angle_type    MAX_RESET      = 8'd150;
   localparam angle_type    OPEN_RESET     = 8'd40;
   localparam angle_type    GRAB_RESET     = 8'd120;
   localparam angle_type    RELEASE_RESET  = 8'd70;
   localparam angle_type    STOP_RESET     = 8'd90;
   localparam angle_type    HOME_ANGLE     = 8'd90;

   localparam interval_type ELAPSED_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAB     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP     = 3'd7;

   // Start actions
   localparam logic [ACTION_W-1:0] ACT_OPEN    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_GRAB    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd4;

   // Motion states
   localparam mode_type MODE_IDLE  = 3'd0;
   localparam mode_type MODE_FAULT = 3'd5;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Clamp a preset into [lo, hi]; when they cross, a value below lo gets lo, any other gets hi.
   function automatic angle_type clamp_angle(angle_type a, angle_type lo, angle_type hi);
      angle_type r;
      if (a < lo) begin
         r = lo;
      end else if (a > hi) begin
         r = hi;
      end else begin
         r = a;
      end
      return r;
   endfunction

   function automatic logic busy_of(mode_type m);
      return (m != MODE_IDLE) && (m != MODE_FAULT);
   endfunction

endpackage

>>> src/msss_slew_unit.sv
// ----------------------------------------------------------------------------
// msss_slew_unit: one-channel slew step
// Moves one angle at most step_size toward its target; flags a move.
// ----------------------------------------------------------------------------
module msss_slew_unit (
   input  msss_pkg::angle_type cur_angle,
   input  msss_pkg::angle_type tgt_angle,
   input  msss_pkg::angle_type step_size,
   output msss_pkg::angle_type next_angle,
   output logic                moved
);
   import msss_pkg::*;

   angle_type diff;

   always_comb begin
      diff       = '0;
      next_angle = cur_angle;
      if (cur_angle < tgt_angle) begin
         diff       = tgt_angle - cur_angle;
         next_angle = (diff > step_size) ? cur_angle + step_size : tgt_angle;
      end else if (cur_angle > tgt_angle) begin
         diff       = cur_angle - tgt_angle;
         next_angle = (diff > step_size) ? cur_angle - step_size : tgt_angle;
      end
   end

   assign moved = (cur_angle != tgt_angle);

endmodule

>>> src/multi_servo_slew_sequencer_core.sv
// ----------------------------------------------------------------------------
// multi_servo_slew_sequencer_core: multi-channel servo slew sequencer
// Ramps NUM_SERVOS angles toward a clamped pose preset, one step per
// move interval, and reports status or the new angles per input word.
// ----------------------------------------------------------------------------
//
//   port group | dir | role          | payload
//   -----------+-----+---------------+----------------------------------------
//   req_*      | in  | command words | tuser: command; tdata: action, drive_error
//   rsp_*      | out | result words  | tuser: is_angle; tlast: last; tdata below
//   csr_*      | in  | register write| index 0..7, data 10 bits
//
// Flow: a start word or a tick that does not step is accepted, then its status
//   word is shown. A stepping tick runs the shared slew unit over the channels
//   one per cycle, then loads each angle word into the output register and
//   shows it until taken, channel by channel.
// req_tready is high only between words; the sequencer owns the shared unit.
// Reset: synchronous, active high; clears registers to defaults, angles and
//   targets to 90, motion state to idle and the interval counter to zero.
// Stalls: rsp_tready held low freezes the result word and the sequencer.
// ----------------------------------------------------------------------------
module multi_servo_slew_sequencer_core #(
   parameter int unsigned NUM_SERVOS = msss_pkg::NUM_SERVOS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // command words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [msss_pkg::REQ_DATA_W-1:0]    req_tdata,  // [2:0] action, [3] drive_error
   input  logic                               req_tuser,  // [0] command
   // result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [msss_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [2:0] channel, [10:3] angle,
                                                          // [11] status, [14:12] pose_state,
                                                          // [15] busy_res
   output logic                               rsp_tuser,  // [0] is_angle
   output logic                               rsp_tlast,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [msss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [msss_pkg::CSR_DATA_W-1:0]    csr_data
);
   import msss_pkg::*;

   localparam int unsigned IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVOS - 1);

   // sequencer states
   localparam logic [1:0] ST_WAIT = 2'd0;  // take a command word
   localparam logic [1:0] ST_STEP = 2'd1;  // slew one channel per cycle
   localparam logic [1:0] ST_LOAD = 2'd2;  // fetch one angle into the output
   localparam logic [1:0] ST_SEND = 2'd3;  // hold the result word until taken

   // configuration
   angle_type    step_ff, min_ff, max_ff;
   angle_type    open_ff, grab_ff, release_ff, stop_ff;
   interval_type interval_ff;

   // block state
   angle_type    cur_ff [NUM_SERVOS];
   angle_type    target_ff, target_in;
   mode_type     mode_ff, mode_in;
   interval_type elapsed_ff, elapsed_in, elapsed_inc;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             moved_ff, moved_in;
   logic [IDX_W+2:0] idx_ext;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_user_ff, rsp_user_in;
   logic      rsp_last_ff, rsp_last_in;
   logic [CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;
   angle_type rsp_angle_ff, rsp_angle_in;
   logic      rsp_status_ff, rsp_status_in;
   mode_type  rsp_mode_ff, rsp_mode_in;

   // decoded command word
   logic                cmd;
   logic [ACTION_W-1:0] action;
   logic                drive_error;
   angle_type           preset;
   logic                preset_ok;

   // shared slew unit
   angle_type slew_next;
   logic      slew_moved;
   logic      cur_we;

   assign cmd         = req_tuser;
   assign action      = req_tdata[2:0];
   assign drive_error = req_tdata[3];
   assign idx_ext     = {3'b000, idx_ff};

   assign req_tready = (state_ff == ST_WAIT);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {busy_of(rsp_mode_ff), rsp_mode_ff, rsp_status_ff,
                        rsp_angle_ff, rsp_chan_ff};

   // saturating millisecond count
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ff + 10'd1;

   // pick the pose preset for a start word
   always_comb begin
      preset    = STOP_RESET;
      preset_ok = 1'b1;
      unique case (action)
         ACT_OPEN:    preset = open_ff;
         ACT_GRAB:    preset = grab_ff;
         ACT_RELEASE: preset = release_ff;
         ACT_STOP:    preset = stop_ff;
         default:     preset_ok = 1'b0;
      endcase
   end

   msss_slew_unit u_slew (
      .cur_angle  (cur_ff[idx_ff]),
      .tgt_angle  (target_ff),
      .step_size  (step_ff),
      .next_angle (slew_next),
      .moved      (slew_moved)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      moved_in      = moved_ff;
      target_in     = target_ff;
      mode_in       = mode_ff;
      elapsed_in    = elapsed_ff;
      cur_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_angle_in  = rsp_angle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mode_in   = rsp_mode_ff;

      unique case (state_ff)
         ST_WAIT: begin
            if (req_tvalid) begin
               // default: a single status word, state unchanged
               state_in      = ST_SEND;
               rsp_valid_in  = 1'b1;
               rsp_user_in   = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_chan_in   = '0;
               rsp_angle_in  = '0;
               rsp_status_in = STATUS_OK;
               rsp_mode_in   = mode_ff;
               priority if (cmd == CMD_START) begin
                  if (preset_ok) begin
                     target_in   = clamp_angle(preset, min_ff, max_ff);
                     mode_in     = action;
                     elapsed_in  = '0;
                     rsp_mode_in = action;
                  end else begin
                     rsp_status_in = STATUS_ERR;
                  end
               end else if (drive_error) begin
                  mode_in       = MODE_FAULT;
                  rsp_mode_in   = MODE_FAULT;
                  rsp_status_in = STATUS_ERR;
               end else if (mode_ff == MODE_IDLE) begin
                  rsp_status_in = STATUS_OK;
               end else if (mode_ff == MODE_FAULT) begin
                  rsp_status_in = STATUS_ERR;
               end else if (elapsed_inc < interval_ff) begin
                  elapsed_in = elapsed_inc;
               end else begin
                  // interval elapsed: run the slew pass, no status word
                  elapsed_in   = '0;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_STEP;
                  idx_in       = '0;
                  moved_in     = 1'b0;
               end
            end
         end
         ST_STEP: begin
            cur_we   = 1'b1;
            moved_in = moved_ff | slew_moved;
            if (idx_ff == LAST_IDX) begin
               // drop back to idle when no channel had to move
               if (!(moved_ff | slew_moved)) begin
                  mode_in = MODE_IDLE;
               end
               idx_in   = '0;
               state_in = ST_LOAD;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_user_in   = 1'b1;
            rsp_last_in   = (idx_ff == LAST_IDX);
            rsp_chan_in   = idx_ext[2:0];
            rsp_angle_in  = cur_ff[idx_ff];
            rsp_status_in = STATUS_OK;
            rsp_mode_in   = mode_ff;
            state_in      = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_WAIT;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_RESET;
         interval_ff <= INTERVAL_RESET;
         min_ff      <= MIN_RESET;
         max_ff      <= MAX_RESET;
         open_ff     <= OPEN_RESET;
         grab_ff     <= GRAB_RESET;
         release_ff  <= RELEASE_RESET;
         stop_ff     <= STOP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP:     step_ff     <= csr_data[7:0];
            CSR_INTERVAL: interval_ff <= csr_data;
            CSR_MIN:      min_ff      <= csr_data[7:0];
            CSR_MAX:      max_ff      <= csr_data[7:0];
            CSR_OPEN:     open_ff     <= csr_data[7:0];
            CSR_GRAB:     grab_ff     <= csr_data[7:0];
            CSR_RELEASE:  release_ff  <= csr_data[7:0];
            CSR_STOP:     stop_ff     <= csr_data[7:0];
         endcase
      end
   end

   // control and motion state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         idx_ff       <= '0;
         moved_ff     <= 1'b0;
         target_ff    <= HOME_ANGLE;
         mode_ff      <= MODE_IDLE;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            cur_ff[i] <= HOME_ANGLE;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         moved_ff     <= moved_in;
         target_ff    <= target_in;
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cur_we) begin
            cur_ff[idx_ff] <= slew_next;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

endmodule

>>> src/msss_checker.sv
// ----------------------------------------------------------------------------
// msss_checker: port-level checks of the servo slew sequencer
// Watches the result channel and the command handshake over time.
// ----------------------------------------------------------------------------
module msss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [msss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);
   import msss_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // a status word always closes its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status word without last");

   // status words carry no channel or angle
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[10:0] == 11'd0)
      else $error("status word with channel or angle set");

   // busy follows the reported motion state
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15] == ((rsp_tdata[14:12] != MODE_IDLE) &&
                                       (rsp_tdata[14:12] != MODE_FAULT)))
      else $error("busy bit disagrees with motion state");

   // no new command is taken while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("command ready while a result is pending");

endmodule

bind multi_servo_slew_sequencer_core msss_checker u_msss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/multi_servo_slew_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_slew_sequencer_core_tb: self-checking bench for the slew core
// Drives start and tick words with random gaps on both stream sides. Each
// accepted command word runs through a local model of the sequencer, and
// every result word is checked field by field against the oldest prediction.
// The run covers status paths, fault entry and exit, clamping, fast and
// frozen ramps, a long result stall, and random phases under random settings.
// ----------------------------------------------------------------------------
module multi_servo_slew_sequencer_core_tb;
   import msss_pkg::*;

   localparam int unsigned N_CH         = NUM_SERVOS_DEFAULT;
   localparam int          SETTLE_TICKS = 24;    // covers a full stepping pass
   localparam int          STALL_LIMIT  = 2000;  // cycles without any handshake
   localparam int          LONG_HOLD    = 300;   // receiver hold-off, in cycles

   // codes with no name in the package: the empty action and the drive_error values
   localparam logic [ACTION_W-1:0] ACT_NONE = 3'd0;
   localparam logic                DRV_OK   = 1'b0;
   localparam logic                DRV_FAIL = 1'b1;

   typedef struct {
      logic                is_angle;
      logic [CHAN_W-1:0]   channel;
      angle_type           angle;
      logic                status;
      mode_type            mstate;
      logic                busy;
      logic                last;
   } servo_word_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // [2:0] action, [3] drive_error
   logic                    req_tuser;   // [0] command
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // [2:0] channel, [10:3] angle, [11] status,
                                         // [14:12] pose_state, [15] busy_res
   logic                    rsp_tuser;   // [0] is_angle
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // model copy of the sequencer
   angle_type     servo_pos  [N_CH];
   angle_type     servo_goal [N_CH];
   mode_type      motion;
   interval_type  elapsed_ms;
   angle_type     cfg_step, cfg_min, cfg_max;
   angle_type     cfg_open, cfg_grab, cfg_release, cfg_stop;
   interval_type  cfg_interval;

   servo_word_type expected_words[$];

   int  error_count;
   int  words_sent;
   int  words_checked;
   int  angle_words;
   int  reg_writes;
   int  idle_cycles;
   int  rsp_hold_req;   // long hold-off handed to the receiver
   bit  no_idle;        // both sides run without gaps while set

   multi_servo_slew_sequencer_core #(
      .NUM_SERVOS (N_CH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Mismatch reporting
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want, input int seq);
      if (got != want) begin
         report_mismatch($sformatf("word %0d field %s got %0d want %0d", seq, name, got, want));
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequencer model
   // -------------------------------------------------------------------------
   function automatic angle_type fit_to_limits(angle_type a);
      // lower bound first: with crossed limits a value below it gets cfg_min, any other cfg_max
      return (a < cfg_min) ? cfg_min : ((a > cfg_max) ? cfg_max : a);
   endfunction

   task automatic push_word(input logic is_ang, input logic [CHAN_W-1:0] ch,
                            input angle_type ang, input logic stat, input logic fin);
      servo_word_type w;
      w.is_angle = is_ang;
      w.channel  = ch;
      w.angle    = ang;
      w.status   = stat;
      w.mstate   = motion;
      w.busy     = (motion != MODE_IDLE) && (motion != MODE_FAULT);
      w.last     = fin;
      expected_words.push_back(w);
   endtask

   task automatic load_defaults();
      for (int i = 0; i < N_CH; i++) begin
         servo_pos[i]  = HOME_ANGLE;
         servo_goal[i] = HOME_ANGLE;
      end
      motion       = MODE_IDLE;
      elapsed_ms   = '0;
      cfg_step     = STEP_RESET;
      cfg_interval = INTERVAL_RESET;
      cfg_min      = MIN_RESET;
      cfg_max      = MAX_RESET;
      cfg_open     = OPEN_RESET;
      cfg_grab     = GRAB_RESET;
      cfg_release  = RELEASE_RESET;
      cfg_stop     = STOP_RESET;
      expected_words.delete();
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_STEP:     cfg_step     = val[ANGLE_W-1:0];
         CSR_INTERVAL: cfg_interval = val;
         CSR_MIN:      cfg_min      = val[ANGLE_W-1:0];
         CSR_MAX:      cfg_max      = val[ANGLE_W-1:0];
         CSR_OPEN:     cfg_open     = val[ANGLE_W-1:0];
         CSR_GRAB:     cfg_grab     = val[ANGLE_W-1:0];
         CSR_RELEASE:  cfg_release  = val[ANGLE_W-1:0];
         CSR_STOP:     cfg_stop     = val[ANGLE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic predict_word(input logic cmd, input logic [ACTION_W-1:0] act, input logic derr);
      angle_type preset;
      angle_type goal;
      logic      known;
      logic      settled;
      known   = 1'b1;
      settled = 1'b1;
      preset  = '0;
      if (cmd == CMD_START) begin
         case (act)
            ACT_OPEN:    preset = cfg_open;
            ACT_GRAB:    preset = cfg_grab;
            ACT_RELEASE: preset = cfg_release;
            ACT_STOP:    preset = cfg_stop;
            default:     known  = 1'b0;
         endcase
         if (known) begin
            goal = fit_to_limits(preset);
            for (int i = 0; i < N_CH; i++) servo_goal[i] = goal;
            motion     = mode_type'(act);
            elapsed_ms = '0;
         end
         push_word(1'b0, '0, '0, known ? STATUS_OK : STATUS_ERR, 1'b1);
      end else if (derr) begin
         motion = MODE_FAULT;
         push_word(1'b0, '0, '0, STATUS_ERR, 1'b1);
      end else if (motion == MODE_IDLE) begin
         push_word(1'b0, '0, '0, STATUS_OK, 1'b1);
      end else if (motion == MODE_FAULT) begin
         push_word(1'b0, '0, '0, STATUS_ERR, 1'b1);
      end else begin
         if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
         if (elapsed_ms < cfg_interval) begin
            push_word(1'b0, '0, '0, STATUS_OK, 1'b1);
         end else begin
            elapsed_ms = '0;
            for (int i = 0; i < N_CH; i++) begin
               if (servo_pos[i] < servo_goal[i]) begin
                  settled = 1'b0;
                  servo_pos[i] = (servo_goal[i] - servo_pos[i] > cfg_step) ?
                                 servo_pos[i] + cfg_step : servo_goal[i];
               end else if (servo_pos[i] > servo_goal[i]) begin
                  settled = 1'b0;
                  servo_pos[i] = (servo_pos[i] - servo_goal[i] > cfg_step) ?
                                 servo_pos[i] - cfg_step : servo_goal[i];
               end
            end
            // idle only when nothing had to move before this step
            if (settled) motion = MODE_IDLE;
            for (int i = 0; i < N_CH; i++) begin
               push_word(1'b1, i[CHAN_W-1:0], servo_pos[i], STATUS_OK, i == N_CH - 1);
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Scoreboard: predict on accepted command words, check each result word
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      servo_word_type want;
      if (reset) begin
         load_defaults();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_data);
            reg_writes++;
         end
         // predict before checking so a same-edge result finds its entry
         if (req_tvalid && req_tready) begin
            predict_word(req_tuser, req_tdata[ACTION_W-1:0], req_tdata[ACTION_W]);
            words_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                         words_checked));
            end else begin
               want = expected_words.pop_front();
               check_field("is_angle", rsp_tuser, want.is_angle, words_checked);
               check_field("channel", rsp_tdata[2:0], want.channel, words_checked);
               check_field("angle", rsp_tdata[10:3], want.angle, words_checked);
               check_field("status", rsp_tdata[11], want.status, words_checked);
               check_field("pose_state", rsp_tdata[14:12], want.mstate, words_checked);
               check_field("busy_res", rsp_tdata[15], want.busy, words_checked);
               check_field("last", rsp_tlast, want.last, words_checked);
               if (want.is_angle) angle_words++;
            end
            words_checked++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when no channel moves a word for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver: random gaps per word, plus an occasional long hold-off
   // -------------------------------------------------------------------------
   initial begin : rsp_sink
      int gap;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (rsp_hold_req > 0) begin
            gap          = rsp_hold_req;
            rsp_hold_req = 0;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         // hold ready until a word goes through
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // -------------------------------------------------------------------------
   // Command and register drivers
   // -------------------------------------------------------------------------
   task automatic send_word(input logic cmd, input logic [ACTION_W-1:0] act, input logic derr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - ACTION_W - 1){1'b0}}, derr, act};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // 8-bit register value, sometimes with junk above bit 7 that must be dropped
   function automatic logic [CSR_DATA_W-1:0] byte_reg(input int v);
      logic [CSR_DATA_W-ANGLE_W-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? (CSR_DATA_W - ANGLE_W)'($urandom) : '0;
      return {junk, v[ANGLE_W-1:0]};
   endfunction

   // drop valid, drain all predictions, then let the sequencer go quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic random_tick();
      send_word(CMD_TICK, ACTION_W'($urandom), DRV_OK);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Idle ticks, fault entry, ticks in fault, every action code from fault.
   task automatic test_status_paths();
      send_word(CMD_TICK, ACT_NONE, DRV_OK);
      send_word(CMD_TICK, ACT_NONE, DRV_FAIL);
      send_word(CMD_TICK, ACT_NONE, DRV_OK);
      // first valid action in this sweep leaves fault; unknown codes report errors
      for (int a = 0; a < (1 << ACTION_W); a++) begin
         send_word(CMD_START, a[ACTION_W-1:0], DRV_OK);
      end
      send_word(CMD_TICK, ACT_NONE, DRV_OK);
      settle();
   endtask

   // A step of 180, interval zero, full-range presets, crossed limits, frozen
   // step, longest interval.
   task automatic test_ramp_extremes();
      write_reg(CSR_STEP, byte_reg(180));
      write_reg(CSR_INTERVAL, '0);
      write_reg(CSR_MIN, byte_reg(0));
      write_reg(CSR_MAX, byte_reg(255));
      write_reg(CSR_OPEN, byte_reg(0));
      write_reg(CSR_GRAB, byte_reg(255));
      send_word(CMD_START, ACT_GRAB, DRV_OK);
      repeat (3) send_word(CMD_TICK, ACT_NONE, DRV_OK);   // reach, settle to idle, idle
      send_word(CMD_START, ACT_OPEN, DRV_OK);
      repeat (3) send_word(CMD_TICK, ACT_NONE, DRV_OK);
      settle();

      // min above max: the lower bound wins
      write_reg(CSR_MIN, byte_reg(100));
      write_reg(CSR_MAX, byte_reg(50));
      write_reg(CSR_RELEASE, byte_reg(30));
      write_reg(CSR_STOP, byte_reg(200));
      send_word(CMD_START, ACT_RELEASE, DRV_OK);
      send_word(CMD_TICK, ACT_NONE, DRV_OK);
      settle();

      // zero step: angles freeze and the state stays busy
      write_reg(CSR_STEP, '0);
      write_reg(CSR_INTERVAL, 10'd1);
      send_word(CMD_START, ACT_STOP, DRV_OK);
      repeat (2) send_word(CMD_TICK, ACT_NONE, DRV_OK);
      settle();

      write_reg(CSR_INTERVAL, '1);
      write_reg(CSR_STEP, byte_reg(1));
      send_word(CMD_START, ACT_GRAB, DRV_OK);
      repeat (2) send_word(CMD_TICK, ACT_NONE, DRV_OK);
      send_word(CMD_TICK, ACT_NONE, DRV_FAIL);
      settle();
   endtask

   // Hold the result side off for a long stretch while ticks keep coming.
   task automatic test_result_stall();
      write_reg(CSR_STEP, byte_reg(7));
      write_reg(CSR_INTERVAL, 10'd1);
      write_reg(CSR_MIN, byte_reg(0));
      write_reg(CSR_MAX, byte_reg(180));
      send_word(CMD_START, ACT_OPEN, DRV_OK);
      rsp_hold_req = LONG_HOLD;
      repeat (24) random_tick();
      settle();
   endtask

   task automatic randomize_regs();
      int v;
      case ($urandom_range(0, 9))
         0:       v = 0;
         1:       v = 180;
         2:       v = 255;
         default: v = $urandom_range(1, 40);
      endcase
      write_reg(CSR_STEP, byte_reg(v));
      case ($urandom_range(0, 7))
         0:       write_reg(CSR_INTERVAL, '0);
         1:       write_reg(CSR_INTERVAL, CSR_DATA_W'($urandom_range(5, 30)));
         default: write_reg(CSR_INTERVAL, CSR_DATA_W'($urandom_range(1, 3)));
      endcase
      // mostly sane limits, sometimes anything including crossed ones
      write_reg(CSR_MIN, byte_reg(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 60)));
      write_reg(CSR_MAX, byte_reg(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(100, 180)));
      write_reg(CSR_OPEN, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_GRAB, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_RELEASE, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_STOP, byte_reg($urandom_range(0, 255)));
   endtask

   // Random phases: new settings, a start to get moving, then mostly ticks.
   task automatic test_random_phases(input int phases, input int per_phase);
      int roll;
      for (int p = 0; p < phases; p++) begin
         randomize_regs();
         no_idle = (p % 4 == 3);
         send_word(CMD_START, ACTION_W'($urandom_range(ACT_OPEN, ACT_STOP)), 1'($urandom));
         for (int k = 1; k < per_phase; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               send_word(CMD_START, ACTION_W'($urandom_range(ACT_OPEN, ACT_STOP)),
                         1'($urandom));
            end else if (roll < 15) begin
               // unknown codes: the empty action and the ones above stop
               send_word(CMD_START, ($urandom_range(0, 3) == 0) ? ACT_NONE
                         : ACTION_W'($urandom_range(ACT_STOP + 1, (1 << ACTION_W) - 1)),
                         1'($urandom));
            end else if (roll < 19) begin
               send_word(CMD_TICK, ACTION_W'($urandom), DRV_FAIL);
            end else begin
               random_tick();
            end
         end
         settle();
         no_idle = 1'b0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_seq
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      error_count  = 0;
      words_sent   = 0;
      words_checked = 0;
      angle_words  = 0;
      reg_writes   = 0;
      idle_cycles  = 0;
      rsp_hold_req = 0;
      no_idle      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_status_paths();
      test_ramp_extremes();
      test_result_stall();
      test_random_phases(8, 30);

      settle();
      if (expected_words.size() != 0) begin
         report_mismatch($sformatf("%0d predicted words never arrived", expected_words.size()));
      end
      $display("Sent %0d command words and %0d register writes; checked %0d result words",
               words_sent, reg_writes, words_checked);
      $display("(%0d angle words) across fault, clamp, frozen-step and long-stall cases.",
               angle_words);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
